/* sv/tlps_pkg.sv */
package tlps_pkg;

    // register map, one 32-bit word per register
    localparam int NUM_REGS = 7;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_MAX_POINTS = 3'd0;
    localparam reg_idx_t REG_RAW_X_MIN  = 3'd1;
    localparam reg_idx_t REG_RAW_X_MAX  = 3'd2;
    localparam reg_idx_t REG_RAW_Y_MIN  = 3'd3;
    localparam reg_idx_t REG_RAW_Y_MAX  = 3'd4;
    localparam reg_idx_t REG_DISP_X_MAX = 3'd5;
    localparam reg_idx_t REG_DISP_Y_MAX = 3'd6;

    localparam logic [3:0] MAX_POINTS_RST = 4'd1;

    // stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // coordinate and arithmetic widths
    localparam int COORD_W = 12;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = COORD_W + CFG_W;
    localparam int STEP_W  = $clog2(PROD_W + 1);

    // item kinds on the input tuser
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

/* sv/touch_latch_publish_scaler.sv */
// Touch report block. Poll samples (s_tuser = 0) update the latched finger
// position, gesture start point and pending-tap flag and give no result. A
// read request (s_tuser = 1) gives exactly one result: pressed on m_tuser
// and the rescaled X and Y on m_tdata (zero when released). A pressed read
// runs through a decision step, then per axis a setup step holding the
// 12x16 multiply, the shared restoring divider (one quotient bit a cycle)
// and a clamp step, X first then Y, then a step to load the output
// register. An axis that passes through unscaled or sits at or below the
// raw minimum ends in its setup step and skips the divider and the clamp. A
// released read goes from the decision straight to the load step. The load
// waits while the output register still holds a result that has not been
// taken. s_tready is low while a read is being worked on; a finished result
// waits in the output register while new items are taken.
module touch_latch_publish_scaler
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status_byte[7:0], x_high[15:8], x_low[23:16], y_high[31:24], y_low[39:32]
    input  logic [tlps_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  logic                            s_tuser,
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[15:0], out_y[31:16]
    output logic [tlps_pkg::OUT_DATA_W-1:0] m_tdata,
    // pressed[0]
    output logic                            m_tuser,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlps_pkg::ADDR_W-1:0]     paddr,
    input  logic [tlps_pkg::DATA_W-1:0]     pwdata,
    output logic [tlps_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    import tlps_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

    state_t               state_reg;

    // configuration registers
    logic [3:0]           max_points_reg;
    logic [CFG_W-1:0]     raw_x_min_reg;
    logic [CFG_W-1:0]     raw_x_max_reg;
    logic [CFG_W-1:0]     raw_y_min_reg;
    logic [CFG_W-1:0]     raw_y_max_reg;
    logic [CFG_W-1:0]     disp_x_max_reg;
    logic [CFG_W-1:0]     disp_y_max_reg;

    // touch tracking state
    logic                 finger_is_down_reg;
    logic                 tap_pending_reg;
    logic                 press_sent_reg;
    logic [COORD_W-1:0]   last_x_reg;
    logic [COORD_W-1:0]   last_y_reg;
    logic [COORD_W-1:0]   start_x_reg;
    logic [COORD_W-1:0]   start_y_reg;
    logic [COORD_W-1:0]   sent_x_reg;
    logic [COORD_W-1:0]   sent_y_reg;

    // read work registers
    logic                 pressed_reg;
    logic [COORD_W-1:0]   ox_reg;
    logic [COORD_W-1:0]   oy_reg;
    logic                 axis_reg;
    logic [PROD_W-1:0]    num_reg;
    logic [CFG_W-1:0]     den_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [CFG_W-1:0]     res_x_reg;
    logic [CFG_W-1:0]     res_y_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // input field split
    logic [3:0]           in_cnt;
    logic [COORD_W-1:0]   in_x;
    logic [COORD_W-1:0]   in_y;
    logic                 in_touch;
    logic                 in_take;

    // read decision
    logic                 rd_tap;
    logic                 rd_active;
    logic                 rd_moved;
    logic                 rd_pressed;
    logic [COORD_W-1:0]   rd_x;
    logic [COORD_W-1:0]   rd_y;

    // per-axis setup
    logic [COORD_W-1:0]   ax_v;
    logic [CFG_W-1:0]     ax_lo;
    logic [CFG_W-1:0]     ax_hi;
    logic [CFG_W-1:0]     ax_dmax;
    logic                 ax_bypass;
    logic                 ax_zero;
    logic [COORD_W-1:0]   ax_diff;
    logic [PROD_W-1:0]    ax_prod;

    // divider step and clamp
    logic [CFG_W:0]       div_shift;
    logic                 div_bit;
    logic [CFG_W-1:0]     rem_next;
    logic [PROD_W-1:0]    num_next;
    logic [CFG_W-1:0]     clamp_val;

    // config access
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic                 out_free;
    logic                 out_load;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign out_load = (state_reg == ST_DONE) & out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // register read back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_MAX_POINTS: prdata = {{(DATA_W-4){1'b0}}, max_points_reg};
            REG_RAW_X_MIN:  prdata = {{(DATA_W-CFG_W){1'b0}}, raw_x_min_reg};
            REG_RAW_X_MAX:  prdata = {{(DATA_W-CFG_W){1'b0}}, raw_x_max_reg};
            REG_RAW_Y_MIN:  prdata = {{(DATA_W-CFG_W){1'b0}}, raw_y_min_reg};
            REG_RAW_Y_MAX:  prdata = {{(DATA_W-CFG_W){1'b0}}, raw_y_max_reg};
            REG_DISP_X_MAX: prdata = {{(DATA_W-CFG_W){1'b0}}, disp_x_max_reg};
            REG_DISP_Y_MAX: prdata = {{(DATA_W-CFG_W){1'b0}}, disp_y_max_reg};
            default:        prdata = '0;
        endcase
    end

    // poll sample decode
    assign in_cnt   = s_tdata[3:0];
    assign in_x     = {s_tdata[11:8], s_tdata[23:16]};
    assign in_y     = {s_tdata[27:24], s_tdata[39:32]};
    assign in_touch = (in_cnt != 4'd0) && (in_cnt <= max_points_reg);

    // report decision for a read request
    assign rd_tap     = ~finger_is_down_reg & tap_pending_reg;
    assign rd_active  = finger_is_down_reg | rd_tap;
    assign rd_moved   = press_sent_reg &&
                        ((last_x_reg != sent_x_reg) || (last_y_reg != sent_y_reg));
    assign rd_pressed = rd_active | rd_moved;
    assign rd_x       = (rd_active && !press_sent_reg) ? start_x_reg : last_x_reg;
    assign rd_y       = (rd_active && !press_sent_reg) ? start_y_reg : last_y_reg;

    // axis operand select and multiply
    always_comb
    begin
        ax_v      = axis_reg ? oy_reg : ox_reg;
        ax_lo     = axis_reg ? raw_y_min_reg : raw_x_min_reg;
        ax_hi     = axis_reg ? raw_y_max_reg : raw_x_max_reg;
        ax_dmax   = axis_reg ? disp_y_max_reg : disp_x_max_reg;
        ax_bypass = (ax_hi <= ax_lo) || (ax_dmax == '0);
        ax_zero   = {{(CFG_W-COORD_W){1'b0}}, ax_v} <= ax_lo;
        ax_diff   = ax_v - ax_lo[COORD_W-1:0];
        ax_prod   = {{CFG_W{1'b0}}, ax_diff} * {{COORD_W{1'b0}}, ax_dmax};
    end

    // one restoring divide step, quotient bits shift into num
    always_comb
    begin
        div_shift = {rem_reg, num_reg[PROD_W-1]};
        div_bit   = div_shift >= {1'b0, den_reg};
        rem_next  = div_bit ? CFG_W'(div_shift - {1'b0, den_reg}) : div_shift[CFG_W-1:0];
        num_next  = {num_reg[PROD_W-2:0], div_bit};
        clamp_val = (num_reg > {{COORD_W{1'b0}}, ax_dmax}) ? ax_dmax : num_reg[CFG_W-1:0];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            max_points_reg     <= MAX_POINTS_RST;
            raw_x_min_reg      <= '0;
            raw_x_max_reg      <= '0;
            raw_y_min_reg      <= '0;
            raw_y_max_reg      <= '0;
            disp_x_max_reg     <= '0;
            disp_y_max_reg     <= '0;
            finger_is_down_reg <= 1'b0;
            tap_pending_reg    <= 1'b0;
            press_sent_reg     <= 1'b0;
            last_x_reg         <= '0;
            last_y_reg         <= '0;
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            sent_x_reg         <= '0;
            sent_y_reg         <= '0;
            pressed_reg        <= 1'b0;
            ox_reg             <= '0;
            oy_reg             <= '0;
            axis_reg           <= 1'b0;
            num_reg            <= '0;
            den_reg            <= '0;
            rem_reg            <= '0;
            step_reg           <= '0;
            res_x_reg          <= '0;
            res_y_reg          <= '0;
            m_tvalid_reg       <= 1'b0;
            m_tdata_reg        <= '0;
            m_tuser_reg        <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_MAX_POINTS: max_points_reg <= pwdata[3:0];
                    REG_RAW_X_MIN:  raw_x_min_reg  <= pwdata[CFG_W-1:0];
                    REG_RAW_X_MAX:  raw_x_max_reg  <= pwdata[CFG_W-1:0];
                    REG_RAW_Y_MIN:  raw_y_min_reg  <= pwdata[CFG_W-1:0];
                    REG_RAW_Y_MAX:  raw_y_max_reg  <= pwdata[CFG_W-1:0];
                    REG_DISP_X_MAX: disp_x_max_reg <= pwdata[CFG_W-1:0];
                    REG_DISP_Y_MAX: disp_y_max_reg <= pwdata[CFG_W-1:0];
                    default:        ;
                endcase
            end

            // result register fills from the done state, drains on an output transfer
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take && s_tuser == FUNC_POLL)
                    begin
                        if (in_touch)
                        begin
                            if (!finger_is_down_reg)
                            begin
                                start_x_reg <= in_x;
                                start_y_reg <= in_y;
                            end
                            finger_is_down_reg <= 1'b1;
                            tap_pending_reg    <= 1'b1;
                            last_x_reg         <= in_x;
                            last_y_reg         <= in_y;
                        end
                        else
                            finger_is_down_reg <= 1'b0;
                    end
                    else if (in_take)
                    begin
                        tap_pending_reg <= 1'b0;
                        pressed_reg     <= rd_pressed;
                        ox_reg          <= rd_x;
                        oy_reg          <= rd_y;
                        axis_reg        <= 1'b0;
                        res_x_reg       <= '0;
                        res_y_reg       <= '0;
                        if (rd_active)
                            press_sent_reg <= 1'b1;
                        else if (!rd_moved)
                            press_sent_reg <= 1'b0;
                        if (rd_pressed)
                        begin
                            sent_x_reg <= rd_x;
                            sent_y_reg <= rd_y;
                            state_reg  <= ST_SETUP;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end

                ST_SETUP:
                begin
                    num_reg  <= ax_prod;
                    den_reg  <= ax_hi - ax_lo;
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (ax_bypass || ax_zero)
                    begin
                        // pass-through or below the raw minimum
                        if (axis_reg)
                            res_y_reg <= ax_bypass ? {{(CFG_W-COORD_W){1'b0}}, ax_v} : '0;
                        else
                            res_x_reg <= ax_bypass ? {{(CFG_W-COORD_W){1'b0}}, ax_v} : '0;
                        axis_reg  <= 1'b1;
                        state_reg <= axis_reg ? ST_DONE : ST_SETUP;
                    end
                    else
                        state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    num_reg  <= num_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(PROD_W - 1))
                        state_reg <= ST_STORE;
                end

                ST_STORE:
                begin
                    if (axis_reg)
                        res_y_reg <= clamp_val;
                    else
                        res_x_reg <= clamp_val;
                    axis_reg  <= 1'b1;
                    state_reg <= axis_reg ? ST_DONE : ST_SETUP;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tuser_reg  <= pressed_reg;
                        m_tdata_reg  <= {res_y_reg, res_x_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // a released report carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("released result with nonzero coordinates");

    // the divider never runs on an empty raw span
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("divide by zero span");

    // a read request closes the input until its result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_READ |=> !s_tready)
        else $error("input reopened during a read");

    // a new result only comes from the final sequencer state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");
`endif

endmodule
